// ----- hdl/hie_pkg.sv -----
// ----------------------------------------------------------------------------
// hie_pkg: shared types, constants and functions for the Hilbert encoder
// Holds the payload widths, the per-stage carry record and the one-level
// Hilbert step used by every pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

package hie_pkg;

   // payload widths fixed by the channel definition
   localparam int HIE_COORD_W = 32;
   localparam int HIE_KEY_W   = 64;

   // curve levels resolved in one pipeline stage
   localparam int HIE_STAGE_LEVELS = 4;

   // digit codes that drive the transform and the rotation
   localparam logic [1:0] HIE_DIGIT_LOW = 2'd0;
   localparam logic [1:0] HIE_DIGIT_TOP = 2'd3;
   localparam logic [1:0] HIE_TT_MASK   = 2'd3;

   // running transform and rotation handed from level to level
   typedef struct packed {
      logic [1:0] w;
      logic       rot;
   } hie_xform_type;

   // everything a stage passes to the next one
   typedef struct packed {
      logic [HIE_COORD_W-1:0] x;
      logic [HIE_COORD_W-1:0] y;
      logic [HIE_KEY_W-1:0]   key;
      hie_xform_type          xf;
   } hie_stage_type;

   // result of one curve level: the digit and the updated transform
   typedef struct packed {
      logic [1:0]    digit;
      hie_xform_type xf;
   } hie_level_type;

   // one level: xor with transform, rotate, Gray-decode, update transform
   function automatic hie_level_type hie_level(logic [1:0] pair, hie_xform_type xf);
      logic [1:0]    t;
      logic [1:0]    s;
      hie_level_type r;
      t = pair ^ xf.w;
      s = xf.rot ? {t[0], t[1]} : t;
      r.digit = {s[1], s[1] ^ s[0]};
      r.xf.w  = xf.w ^ ((r.digit == HIE_DIGIT_TOP) ? HIE_TT_MASK : 2'b00);
      r.xf.rot = xf.rot ^ ((r.digit == HIE_DIGIT_LOW) || (r.digit == HIE_DIGIT_TOP));
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/hie_req_if.sv -----
// ----------------------------------------------------------------------------
// hie_req_if: point channel into the Hilbert encoder
// Valid/ready channel carrying one two-dimensional point per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hie_req_if
   import hie_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [HIE_COORD_W-1:0] coord_x;
   logic [HIE_COORD_W-1:0] coord_y;

   modport source (output valid, output coord_x, output coord_y, input ready);
   modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

`default_nettype wire

// ----- hdl/hie_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hie_rsp_if: key channel out of the Hilbert encoder
// Valid/ready channel carrying one 64-bit curve index per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface hie_rsp_if
   import hie_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [HIE_KEY_W-1:0] curve_index;

   modport source (output valid, output curve_index, input ready);
   modport sink   (input valid, input curve_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/hie_stage.sv -----
// ----------------------------------------------------------------------------
// hie_stage: one pipeline stage of the Hilbert encoder
// Resolves HIE_STAGE_LEVELS curve levels and registers the carry record,
// with a valid bit and local back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module hie_stage
   import hie_pkg::*;
#(
   parameter int LEVELS    = 32,
   parameter int STAGE_IDX = 0
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   up_valid,
   output      logic   up_ready,
   input  wire hie_stage_type up_data,
   output      logic   dn_valid,
   input  wire logic   dn_ready,
   output hie_stage_type dn_data
);

   logic          valid_ff;
   logic          valid_in;
   hie_stage_type data_ff;
   hie_stage_type data_in;

   hie_xform_type            xf_chain  [0:HIE_STAGE_LEVELS];
   logic [HIE_KEY_W-1:0]     key_chain [0:HIE_STAGE_LEVELS];

   assign xf_chain[0]  = up_data.xf;
   assign key_chain[0] = up_data.key;

   // unroll the levels of this stage, top coordinate bit first
   for (genvar j = 0; j < HIE_STAGE_LEVELS; j++) begin : g_lvl
      localparam int LVL = LEVELS - 1 - (STAGE_IDX * HIE_STAGE_LEVELS + j);
      if (LVL >= 0) begin : g_act
         hie_level_type res;
         assign res = hie_level({up_data.x[LVL], up_data.y[LVL]}, xf_chain[j]);
         assign xf_chain[j+1]  = res.xf;
         assign key_chain[j+1] = key_chain[j]
                                 | ({{(HIE_KEY_W-2){1'b0}}, res.digit} << (2 * LVL));
      end else begin : g_pass
         assign xf_chain[j+1]  = xf_chain[j];
         assign key_chain[j+1] = key_chain[j];
      end
   end

   // take a new transfer when empty or when the held one leaves
   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      data_in     = up_data;
      data_in.xf  = xf_chain[HIE_STAGE_LEVELS];
      data_in.key = key_chain[HIE_STAGE_LEVELS];
      valid_in    = up_ready ? up_valid : valid_ff;
   end

   // advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture payload on an accepted transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

`default_nettype wire

// ----- hdl/hilbert_index_encode_2d.sv -----
// ----------------------------------------------------------------------------
// hilbert_index_encode_2d: two-dimensional Hilbert curve index encoder
// Maps a point (coord_x, coord_y) to its 64-bit Hilbert key through a
// pipeline of stages, four curve levels per stage.
//
//   channel   direction  handshake            payload
//   req_ch    in         valid / ready        coord_x[31:0], coord_y[31:0]
//   rsp_ch    out        valid / ready        curve_index[63:0]
//
// One point per cycle sustained while rsp_ch does not stall; the result is
// registered once in each four-level stage.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on rsp_ch backs up stage by stage through the ready chain; a full
// stage holds its transfer, and bubbles are squeezed out as it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module hilbert_index_encode_2d
   import hie_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   hie_req_if.sink    req_ch,
   hie_rsp_if.source  rsp_ch
);

   localparam int LEVELS     = (COORD_BITS > HIE_COORD_W) ? HIE_COORD_W :
                               ((COORD_BITS < 1) ? 1 : COORD_BITS);
   localparam int NUM_STAGES = (LEVELS + HIE_STAGE_LEVELS - 1) / HIE_STAGE_LEVELS;

   logic          stage_valid [0:NUM_STAGES];
   logic          stage_ready [0:NUM_STAGES];
   hie_stage_type stage_data  [0:NUM_STAGES];
   logic [NUM_STAGES-1:0] occ;

   // seed the first stage with a clear key and transform
   assign stage_data[0] = '{x: req_ch.coord_x, y: req_ch.coord_y, key: '0, xf: '0};

   assign stage_valid[0] = req_ch.valid;
   assign req_ch.ready   = stage_ready[0];

   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      hie_stage #(
         .LEVELS    (LEVELS),
         .STAGE_IDX (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stage_valid[i]),
         .up_ready (stage_ready[i]),
         .up_data  (stage_data[i]),
         .dn_valid (stage_valid[i+1]),
         .dn_ready (stage_ready[i+1]),
         .dn_data  (stage_data[i+1])
      );
      assign occ[i] = stage_valid[i+1];
   end

   // drive the result channel from the last stage
   assign stage_ready[NUM_STAGES] = rsp_ch.ready;
   assign rsp_ch.valid            = stage_valid[NUM_STAGES];
   assign rsp_ch.curve_index      = stage_data[NUM_STAGES].key;

`ifndef SYNTH
   // occupancy follows transfers in and out exactly
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(occ) == $past($countones(occ))
                + int'($past(req_ch.valid && req_ch.ready))
                - int'($past(rsp_ch.valid && rsp_ch.ready))))
      else $error("pipeline occupancy does not match transfers");

   // a full, stalled pipeline takes no new transfer
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&occ && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("transfer accepted into a full stalled pipeline");

   // key bits above the curve order stay clear
   a_key_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.curve_index >> (2 * LEVELS)) == '0))
      else $error("curve index has bits above the curve order");
`endif

endmodule

`default_nettype wire

// ----- tb/hilbert_index_encode_2d_test.sv -----
// ----------------------------------------------------------------------------
// hilbert_index_encode_2d_test: self-checking bench for the 2-D Hilbert encoder
// Streams points through the request channel and computes each expected
// curve index with a local bit-serial encoder. Every key on the response
// channel is checked in order. Sender bursts, receiver stall patterns, a long
// output hold-off and a full drain give coverage of stalls and bubbles.
// ----------------------------------------------------------------------------

module hilbert_index_encode_2d_test
   import hie_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS   = 32;
   localparam int CURVE_LEVELS = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 1) ? 1 : COORD_BITS);
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;

   // digit values that flip the transform and the rotation
   localparam logic [1:0] DIGIT_ENTRY = 2'd0;
   localparam logic [1:0] DIGIT_EXIT  = 2'd3;
   localparam logic [1:0] FLIP_BOTH   = 2'b11;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_RANDOM,
      SINK_PATTERN
   } sink_mode_type;

   logic clock;
   logic reset;

   hie_req_if req_ch ();
   hie_rsp_if rsp_ch ();

   hilbert_index_encode_2d #(
      .COORD_BITS (COORD_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [HIE_KEY_W-1:0] expected_keys[$];
   int                   error_count = 0;
   int                   cycle_count = 0;

   // sender pacing
   bit                   bursty     = 1'b0;
   int                   burst_left = 0;

   // receiver behaviour
   sink_mode_type        sink_mode     = SINK_OPEN;
   int                   hold_off_len  = 0;
   int                   hold_off_seq  = 0;
   int                   hold_off_seen = 0;
   int                   stall_count   = 0;
   logic [10:0]          stall_pattern = 11'b10110111011;

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bit-serial Hilbert encoder, most significant level first
   function automatic logic [HIE_KEY_W-1:0] hilbert_key(logic [HIE_COORD_W-1:0] x,
                                                        logic [HIE_COORD_W-1:0] y);
      logic [HIE_KEY_W-1:0] key;
      logic [1:0]           w;
      logic [1:0]           tt;
      logic                 rot;
      logic [1:0]           t;
      logic [1:0]           s;
      logic [1:0]           digit;
      key = '0;
      w   = 2'b00;
      tt  = 2'b00;
      rot = 1'b0;
      for (int lvl = CURVE_LEVELS - 1; lvl >= 0; lvl--) begin
         w     = w ^ tt;
         t     = {x[lvl], y[lvl]} ^ w;
         s     = rot ? {t[0], t[1]} : t;
         digit = {s[1], s[1] ^ s[0]};
         key[2*lvl +: 2] = digit;
         tt    = (digit == DIGIT_EXIT) ? FLIP_BOTH : 2'b00;
         if (digit == DIGIT_ENTRY || digit == DIGIT_EXIT)
            rot = ~rot;
      end
      return key;
   endfunction

   // coordinate with a mix of magnitudes and bit shapes
   function automatic logic [HIE_COORD_W-1:0] random_coord();
      logic [HIE_COORD_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: v = $urandom_range(0, 255);
         2: v = ~$urandom_range(0, 255);
         3: v = 32'd1 << $urandom_range(0, 31);
         default: v = $urandom >> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   // offer one point, hold it until transferred, then pace the next one
   task automatic send_point(input logic [HIE_COORD_W-1:0] x,
                             input logic [HIE_COORD_W-1:0] y);
      int gap;
      req_ch.valid   <= 1'b1;
      req_ch.coord_x <= x;
      req_ch.coord_y <= y;
      do @(posedge clock); while (!req_ch.ready);
      expected_keys.push_back(hilbert_key(x, y));
      @(negedge clock);
      if (bursty) begin
         if (burst_left <= 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
      end
   endtask

   // drop valid and hold until every expected key has arrived
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (expected_keys.size() != 0) @(negedge clock);
   endtask

   // corners of the coordinate space and simple bit shapes
   task automatic test_corner_points();
      bursty    = 1'b0;
      sink_mode = SINK_OPEN;
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_point(32'hFFFF_FFFF, 32'h0000_0000);
      send_point(32'h0000_0000, 32'hFFFF_FFFF);
      send_point(32'h8000_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h8000_0000);
      send_point(32'h0000_0001, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h0000_0001);
      send_point(32'h0000_0001, 32'h0000_0001);
      send_point(32'hAAAA_AAAA, 32'h5555_5555);
      send_point(32'h5555_5555, 32'hAAAA_AAAA);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h1234_5678, 32'h9ABC_DEF0);
      wait_for_drain();
   endtask

   // uniform points with bursty sender and alternating random and patterned receiver stalls
   task automatic test_random_bursts();
      bursty = 1'b1;
      for (int i = 0; i < 250; i++) begin
         if (i % 80 == 0)
            sink_mode = (i % 160 == 0) ? SINK_RANDOM : SINK_PATTERN;
         send_point($urandom, $urandom);
      end
      wait_for_drain();
   endtask

   // short walks of neighbouring points from assorted starting points
   task automatic test_neighbour_walks();
      logic [HIE_COORD_W-1:0] x;
      logic [HIE_COORD_W-1:0] y;
      bursty    = 1'b1;
      sink_mode = SINK_PATTERN;
      for (int walk = 0; walk < 10; walk++) begin
         x = random_coord();
         y = random_coord();
         for (int i = 0; i < 20; i++) begin
            send_point(x, y);
            case ($urandom_range(0, 3))
               0: x = x + 1;
               1: x = x - 1;
               2: y = y + 1;
               default: y = y - 1;
            endcase
         end
         if (walk == 4)
            sink_mode = SINK_RANDOM;
      end
      wait_for_drain();
   endtask

   // hold the output off while points keep coming, so the pipe fills and stalls
   task automatic test_output_backpressure();
      bursty    = 1'b0;
      sink_mode = SINK_OPEN;
      hold_off_len = 80;
      hold_off_seq++;
      for (int i = 0; i < 40; i++)
         send_point(random_coord(), random_coord());
      wait_for_drain();
   endtask

   // back-to-back transfers with the output always open
   task automatic test_full_throughput();
      bursty    = 1'b0;
      sink_mode = SINK_OPEN;
      for (int i = 0; i < 100; i++)
         send_point($urandom, $urandom);
      wait_for_drain();
   endtask

   // stimulus sequence
   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.coord_x = '0;
      req_ch.coord_y = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_corner_points();
      test_random_bursts();
      test_output_backpressure();
      test_neighbour_walks();
      test_full_throughput();

      // settle and report
      req_ch.valid <= 1'b0;
      sink_mode = SINK_OPEN;
      while (expected_keys.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // receiver: long hold-off on request, otherwise the selected stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_seq != hold_off_seen) begin
         hold_off_seen = hold_off_seq;
         stall_count   = hold_off_len;
         rsp_ch.ready <= 1'b0;
      end else if (stall_count > 0) begin
         stall_count--;
         rsp_ch.ready <= 1'b0;
      end else begin
         case (sink_mode)
            SINK_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            SINK_PATTERN: begin
               rsp_ch.ready <= stall_pattern[0];
               stall_pattern = {stall_pattern[0], stall_pattern[10:1]};
            end
            default: rsp_ch.ready <= 1'b1;
         endcase
      end
   end

   // compare each transferred key with the oldest expectation
   always @(posedge clock) begin
      logic [HIE_KEY_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_keys.size() == 0) begin
            $error("curve_index: expected none, actual %h", rsp_ch.curve_index);
            error_count++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_ch.curve_index !== want) begin
               $error("curve_index: expected %h, actual %h", want, rsp_ch.curve_index);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

endmodule

// ----- filelist.f -----
hdl/hie_pkg.sv
hdl/hie_req_if.sv
hdl/hie_rsp_if.sv
hdl/hie_stage.sv
hdl/hilbert_index_encode_2d.sv
tb/hilbert_index_encode_2d_test.sv
